### hdl/record_table_sort_search_core_macros.svh
// Assertion macros for the record table core checker.
// Included by the checker file; no other dependencies.
`ifndef RECORD_TABLE_SORT_SEARCH_CORE_MACROS_SVH
`define RECORD_TABLE_SORT_SEARCH_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RTS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RTS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hdl/rts_pkg.sv
// Types and constants shared by the record table core.
// No dependencies.
`default_nettype none
package rts_pkg;
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SORT = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_UPDATE = 2'd3;
  localparam logic [2:0] CR_CODE = 3'd0;
  localparam logic [2:0] CR_NAME = 3'd1;
  localparam logic [2:0] CR_PREFIX = 3'd2;
  localparam logic [2:0] CR_PRICE_UP = 3'd3;
  localparam logic [2:0] CR_PRICE_DN = 3'd4;
  localparam logic [2:0] ORDER_NONE = 3'd7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  criterion;
    logic [63:0] code_text;
    logic [63:0] name_text;
    logic [63:0] category_text;
    logic [63:0] query_text;
    logic [23:0] price_cents;
    logic [15:0] quantity;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] out_code;
    logic [63:0] out_name;
    logic [63:0] out_category;
    logic [23:0] out_price_cents;
    logic [15:0] out_quantity;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] code;
    logic [63:0] name;
    logic [63:0] category;
    logic [23:0] price;
    logic [15:0] quantity;
    logic [22:0] date;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SORT_RD, S_SORT_CMP, S_SCAN_RD, S_SCAN_CHK,
    S_BIN_RD, S_BIN_CHK, S_EMIT, S_NONE
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load_item;   // latch input item
    logic append;      // write latched record at count
    logic set_order;   // current_order <= criterion
    logic rd_a;        // read entries at index a and a-1
    logic swap;        // write swapped pair
    logic init_sort;   // i <= 1, a <= 1
    logic next_i;      // i <= i+1, a <= i+1
    logic dec_a;       // a <= a-1
    logic init_scan;   // a <= 0, hit flags clear
    logic next_scan;   // a <= a+1
    logic init_bin;    // l <= 0, r <= count-1
    logic bin_left;    // l <= m+1
    logic bin_right;   // r <= m-1
    logic write_qty;   // write quantity at index a (midpoint in binary update)
    logic hold_hit;    // capture current entry into output buffer
    logic flush;       // buffered record goes out
    logic none;        // not-found result goes out
    logic last_flag;   // last marker on output
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] criterion;
    logic       order_match;
    logic       full;
    logic       i_done;    // i >= count
    logic       a_zero;
    logic       less;      // entry a before entry a-1
    logic       scan_done; // a >= count
    logic       hit;       // entry a matches query
    logic       have_buf;  // a pending earlier hit is buffered
    logic       bin_done;  // l > r
    logic       bin_cmp_lt;// entry m below query
    logic       out_busy;  // output register full
  } status_t;
endpackage
`default_nettype wire

### hdl/rts_datapath.sv
// Datapath of the record table core: record memory, indexes, compares
// and the output register. Depends on rts_pkg.
`default_nettype none
module rts_datapath import rts_pkg::*; #(
  parameter int NUM_ENTRIES = 64,
  parameter int TEXT_BYTES = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  in_item,
  input  wire cmd_t      cmd,
  output status_t        status,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);
  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  rec_t        mem [NUM_ENTRIES];
  rec_t        rd_a, rd_b;
  in_item_t    item;
  logic [CW-1:0] count;
  logic [2:0]  current_order;
  logic [CW-1:0] i_idx, a_idx;
  logic signed [CW:0] lo, hi;
  logic [IW-1:0] ai, bi;
  rec_t        buf_rec;
  logic        buf_valid;
  logic [63:0] q, qmask;

  function automatic logic [63:0] cut(input logic [63:0] v);
    logic [63:0] r;
    logic stop;
    r = '0;
    stop = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (k >= TEXT_BYTES || v[63-8*k -: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[63-8*k -: 8] = v[63-8*k -: 8];
    end
    return r;
  endfunction

  always_comb begin
    q = cut(item.query_text);
    for (int k = 0; k < 8; k++) qmask[63-8*k -: 8] = (q[63-8*k -: 8] != 8'd0) ? 8'hFF : 8'h00;
  end

  logic signed [CW:0] mid;
  assign mid = lo + ((hi - lo) >>> 1);
  // Binary update probes, captures and writes at the midpoint.
  assign ai = (cmd.init_bin || (status.opcode == OP_UPDATE && status.order_match))
              ? mid[IW-1:0] : a_idx[IW-1:0];
  assign bi = a_idx[IW-1:0] - IW'(1);

  logic [63:0] key_a;
  assign key_a = item.criterion[0] ? rd_a.name : rd_a.code;

  always_comb begin
    status.opcode = item.opcode;
    status.criterion = item.criterion;
    status.order_match = item.criterion == current_order;
    status.full = count == CW'(NUM_ENTRIES);
    status.i_done = i_idx >= count;
    status.a_zero = a_idx == '0;
    case (item.criterion)
      CR_CODE: status.less = rd_a.code < rd_b.code;
      CR_NAME: status.less = rd_a.name < rd_b.name;
      CR_PRICE_UP: status.less = rd_a.price < rd_b.price;
      CR_PRICE_DN: status.less = rd_b.price < rd_a.price;
      default: status.less = 1'b0;
    endcase
    status.scan_done = a_idx >= count;
    case (item.criterion)
      CR_CODE: status.hit = rd_a.code == q;
      CR_NAME: status.hit = rd_a.name == q;
      CR_PREFIX: status.hit = (rd_a.name & qmask) == q;
      default: status.hit = 1'b0;
    endcase
    status.have_buf = buf_valid;
    status.bin_done = lo > hi;
    status.bin_cmp_lt = key_a < q;
    status.out_busy = out_valid && !out_ready;
  end

  // Memory: two registered reads; a swap writes both entries of the pair.
  always_ff @(posedge clk) begin
    rd_a <= mem[ai];
    rd_b <= mem[bi];
    if (cmd.append)
      mem[count[IW-1:0]] <= '{code: cut(item.code_text), name: cut(item.name_text),
                              category: cut(item.category_text), price: item.price_cents,
                              quantity: item.quantity,
                              date: {item.year, item.month, item.day}};
    else if (cmd.swap) begin
      mem[a_idx[IW-1:0]] <= rd_b;
      mem[bi] <= rd_a;
    end else if (cmd.write_qty)
      mem[ai].quantity <= item.quantity;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_item;
    if (cmd.hold_hit) begin
      buf_rec <= rd_a;
      if (cmd.write_qty) buf_rec.quantity <= item.quantity;
    end
    if (cmd.init_sort) begin
      i_idx <= CW'(1);
      a_idx <= CW'(1);
    end else if (cmd.next_i) begin
      i_idx <= i_idx + CW'(1);
      a_idx <= i_idx + CW'(1);
    end else if (cmd.dec_a) a_idx <= a_idx - CW'(1);
    else if (cmd.init_scan) a_idx <= '0;
    else if (cmd.next_scan) a_idx <= a_idx + CW'(1);
    if (cmd.init_bin) begin
      lo <= '0;
      hi <= $signed({1'b0, count}) - (CW+1)'(1);
    end else if (cmd.bin_left) lo <= mid + (CW+1)'(1);
    else if (cmd.bin_right) hi <= mid - (CW+1)'(1);
    if (cmd.write_qty) a_idx <= {{(CW-IW){1'b0}}, ai};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      current_order <= ORDER_NONE;
      out_valid <= 1'b0;
      buf_valid <= 1'b0;
    end else begin
      if (cmd.append) begin
        count <= count + CW'(1);
        current_order <= ORDER_NONE;
      end
      if (cmd.set_order) current_order <= item.criterion;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.init_scan) buf_valid <= 1'b0;
      if (cmd.flush) buf_valid <= 1'b0;
      if (cmd.hold_hit) buf_valid <= 1'b1;
      if (cmd.flush || cmd.none) out_valid <= 1'b1;
      if (cmd.flush) begin
        out_item <= '{found: 1'b1, out_code: buf_rec.code, out_name: buf_rec.name,
                      out_category: buf_rec.category, out_price_cents: buf_rec.price,
                      out_quantity: buf_rec.quantity, out_day: buf_rec.date[4:0],
                      out_month: buf_rec.date[8:5], out_year: buf_rec.date[22:9],
                      last: cmd.last_flag};
      end else if (cmd.none) begin
        out_item <= '0;
        out_item.last <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### hdl/rts_controller.sv
// Controller state machine of the record table core.
// Depends on rts_pkg.
`default_nettype none
module rts_controller import rts_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.opcode)
          OP_LOAD: begin
            if (!status.full) cmd.append = 1'b1;
            state_next = S_IDLE;
          end
          OP_SORT: begin
            if (status.criterion inside {CR_CODE, CR_NAME, CR_PRICE_UP, CR_PRICE_DN}) begin
              cmd.init_sort = 1'b1;
              cmd.set_order = 1'b1;
              state_next = S_SORT_RD;
            end else state_next = S_IDLE;
          end
          OP_SEARCH: begin
            if (status.criterion > CR_PREFIX) state_next = S_NONE;
            else begin
              cmd.init_scan = 1'b1;
              state_next = S_SCAN_RD;
            end
          end
          default: begin
            if (status.criterion > CR_NAME) state_next = S_NONE;
            else if (status.order_match) begin
              cmd.init_bin = 1'b1;
              state_next = S_BIN_RD;
            end else begin
              cmd.init_scan = 1'b1;
              state_next = S_SCAN_RD;
            end
          end
        endcase
      end
      S_SORT_RD: begin
        if (status.i_done) state_next = S_IDLE;
        else if (status.a_zero) begin
          cmd.next_i = 1'b1;
        end else state_next = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (status.less) begin
          cmd.swap = 1'b1;
          cmd.dec_a = 1'b1;
        end else cmd.next_i = 1'b1;
        state_next = S_SORT_RD;
      end
      S_SCAN_RD: begin
        if (status.scan_done) begin
          if (status.have_buf) begin
            if (!status.out_busy) begin
              cmd.flush = 1'b1;
              cmd.last_flag = 1'b1;
              state_next = S_IDLE;
            end
          end else state_next = S_NONE;
        end else state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (status.hit) begin
          if (status.have_buf && status.out_busy) state_next = S_SCAN_CHK;
          else begin
            if (status.have_buf) cmd.flush = 1'b1;
            cmd.hold_hit = 1'b1;
            if (status.opcode == OP_UPDATE) begin
              cmd.write_qty = 1'b1;
              state_next = S_EMIT;
            end else begin
              cmd.next_scan = 1'b1;
              state_next = S_SCAN_RD;
            end
          end
        end else begin
          cmd.next_scan = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_BIN_RD: begin
        if (status.bin_done) state_next = S_NONE;
        else state_next = S_BIN_CHK;
      end
      S_BIN_CHK: begin
        if (status.hit) begin
          cmd.hold_hit = 1'b1;
          cmd.write_qty = 1'b1;
          state_next = S_EMIT;
        end else begin
          if (status.bin_cmp_lt) cmd.bin_left = 1'b1;
          else cmd.bin_right = 1'b1;
          state_next = S_BIN_RD;
        end
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.flush = 1'b1;
          cmd.last_flag = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NONE: begin
        if (!status.out_busy) begin
          cmd.none = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hdl/record_table_sort_search_core.sv
// Record table core: appends records, sorts them in place with a stable
// insertion sort, searches by code, name or name prefix and updates a
// record's quantity. Depends on rts_pkg, rts_controller, rts_datapath.
//
// Channels: in_valid/in_ready/in_item take one command item; out_valid/
// out_ready/out_item return result items. Load and sort return nothing.
// A search returns every match in table order, the final one with last
// set, or a single not-found item (found = 0, last = 1). An update returns
// one item with last set.
// Rate: one item at a time; in_ready is high only between items. A load
// appends in its dispatch step. A sort steps through its read and compare
// states for each compare of the insertion loop, plus a further read step
// when an entry reaches the front. A search or linear update reads and
// checks each record in turn; a binary update reads and checks each probe.
// Results leave through one output register; a further match waits while
// the receiver stalls, so nothing is lost. Reset (rst, synchronous) empties
// the table and marks it unsorted; record contents are not cleared.
`default_nettype none
module record_table_sort_search_core import rts_pkg::*; #(
  parameter int NUM_ENTRIES = 64,
  parameter int TEXT_BYTES = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);
  cmd_t    cmd;
  status_t status;

  // Sequencer: decides each step of the current command.
  rts_controller u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .status, .cmd
  );

  // Table storage, index registers, comparators and output register.
  rts_datapath #(.NUM_ENTRIES(NUM_ENTRIES), .TEXT_BYTES(TEXT_BYTES)) u_dp (
    .clk, .rst, .in_item, .cmd, .status, .out_valid, .out_ready, .out_item
  );
endmodule
`default_nettype wire

### hdl/record_table_sort_search_core_checker.sv
// Port-level checker for the record table core, bound to the top level.
// Depends on rts_pkg and the assertion macro header.
`default_nettype none
`include "record_table_sort_search_core_macros.svh"
module record_table_sort_search_core_checker import rts_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);
  `RTS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item))
  `RTS_ASSERT_IMP(a_none_last, clk, rst, out_valid && !out_item.found, out_item.last)
  `RTS_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `RTS_ASSERT_IMP(a_none_zero, clk, rst, out_valid && !out_item.found, out_item.out_code == 64'd0)
endmodule
bind record_table_sort_search_core record_table_sort_search_core_checker u_chk (.*);
`default_nettype wire

### test/tb.sv
// Testbench for record_table_sort_search_core: random and directed command
// items, a scoreboard class that models the record table. Depends on rts_pkg.
`timescale 1ns / 100ps
module tb;
  import rts_pkg::*;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 50000;
  localparam int RANDOM_ITEMS = 290;

  // Model of the record table and the queue of results it predicts.
  class table_scoreboard;
    rec_t            recs[DEPTH];
    int              count;
    logic [2:0]      order;
    out_item_t       pending_results[$];
    int              errors;

    function new();
      count = 0;
      order = ORDER_NONE;
      errors = 0;
    endfunction

    // Keep bytes up to the first NUL, zero the rest.
    function logic [63:0] cut_text(logic [63:0] v, output int len);
      logic [63:0] r;
      logic        stop;
      r = '0;
      len = 0;
      stop = 0;
      for (int k = 0; k < 8; k++) begin
        if (!stop && v[63-8*k -: 8] != 8'd0) begin
          r[63-8*k -: 8] = v[63-8*k -: 8];
          len++;
        end else begin
          stop = 1;
        end
      end
      return r;
    endfunction

    function logic goes_first(rec_t a, rec_t b, logic [2:0] crit);
      case (crit)
        CR_CODE:     return a.code < b.code;
        CR_NAME:     return a.name < b.name;
        CR_PRICE_UP: return a.price < b.price;
        CR_PRICE_DN: return a.price > b.price;
        default:     return 1'b0;
      endcase
    endfunction

    function out_item_t shown(int idx);
      out_item_t o;
      o = '0;
      o.found = 1'b1;
      o.out_code = recs[idx].code;
      o.out_name = recs[idx].name;
      o.out_category = recs[idx].category;
      o.out_price_cents = recs[idx].price;
      o.out_quantity = recs[idx].quantity;
      o.out_day = recs[idx].date[4:0];
      o.out_month = recs[idx].date[8:5];
      o.out_year = recs[idx].date[22:9];
      return o;
    endfunction

    function void push_none();
      out_item_t o;
      o = '0;
      o.last = 1'b1;
      pending_results.push_back(o);
    endfunction

    // Predict the results of one accepted command item.
    function void note(in_item_t it);
      int          qlen, dummy, j, hits, l, r, m, pos;
      logic [63:0] q, mask, key;
      rec_t        t;
      out_item_t   o;
      q = cut_text(it.query_text, qlen);
      case (it.opcode)
        OP_LOAD: begin
          if (count < DEPTH) begin
            recs[count].code = cut_text(it.code_text, dummy);
            recs[count].name = cut_text(it.name_text, dummy);
            recs[count].category = cut_text(it.category_text, dummy);
            recs[count].price = it.price_cents;
            recs[count].quantity = it.quantity;
            recs[count].date = {it.year, it.month, it.day};
            count++;
            order = ORDER_NONE;
          end
        end
        OP_SORT: begin
          if (it.criterion inside {CR_CODE, CR_NAME, CR_PRICE_UP, CR_PRICE_DN}) begin
            for (int i = 1; i < count; i++) begin
              j = i;
              while (j > 0 && goes_first(recs[j], recs[j-1], it.criterion)) begin
                t = recs[j];
                recs[j] = recs[j-1];
                recs[j-1] = t;
                j--;
              end
            end
            order = it.criterion;
          end
        end
        OP_SEARCH: begin
          mask = (qlen == 0) ? 64'd0 : ~64'd0 << (64 - 8*qlen);
          hits = 0;
          if (it.criterion <= CR_PREFIX) begin
            for (int i = 0; i < count; i++) begin
              if ((it.criterion == CR_CODE && recs[i].code == q) ||
                  (it.criterion == CR_NAME && recs[i].name == q) ||
                  (it.criterion == CR_PREFIX && (recs[i].name & mask) == (q & mask))) begin
                pending_results.push_back(shown(i));
                hits++;
              end
            end
          end
          if (hits == 0) begin
            push_none();
          end else begin
            o = pending_results.pop_back();
            o.last = 1'b1;
            pending_results.push_back(o);
          end
        end
        default: begin
          pos = -1;
          if (it.criterion <= CR_NAME) begin
            if (it.criterion == order) begin
              l = 0;
              r = count - 1;
              while (l <= r && pos < 0) begin
                m = l + (r - l) / 2;
                key = (it.criterion == CR_CODE) ? recs[m].code : recs[m].name;
                if (key == q) pos = m;
                else if (key < q) l = m + 1;
                else r = m - 1;
              end
            end else begin
              for (int i = 0; i < count && pos < 0; i++) begin
                key = (it.criterion == CR_CODE) ? recs[i].code : recs[i].name;
                if (key == q) pos = i;
              end
            end
          end
          if (pos < 0) begin
            push_none();
          end else begin
            recs[pos].quantity = it.quantity;
            o = shown(pos);
            o.last = 1'b1;
            pending_results.push_back(o);
          end
        end
      endcase
    endfunction

    // Compare one result with the oldest prediction.
    function void check(out_item_t got);
      out_item_t want;
      logic      bad;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: %p", got);
        return;
      end
      want = pending_results.pop_front();
      bad = (got.found !== want.found) || (got.out_code !== want.out_code) ||
            (got.out_name !== want.out_name) || (got.out_category !== want.out_category) ||
            (got.out_price_cents !== want.out_price_cents) ||
            (got.out_quantity !== want.out_quantity) || (got.out_day !== want.out_day) ||
            (got.out_month !== want.out_month) || (got.out_year !== want.out_year) ||
            (got.last !== want.last);
      if (bad) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  table_scoreboard sb;
  int send_idle;
  int recv_idle;
  int quiet_cycles;

  always #1 clk = ~clk;

  record_table_sort_search_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // Receiver: check accepted results, stall at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check(out_item);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Hold valid until accepted; keep it high into the next item when no gap.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note(it);
  endtask

  // Short text from a tiny alphabet so that keys collide; sometimes full noise.
  function automatic logic [63:0] pool_text();
    logic [63:0] v;
    int          len;
    v = '0;
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    len = $urandom_range(3);
    for (int k = 0; k < len; k++) v[63-8*k -: 8] = 8'h41 + 8'($urandom_range(2));
    if ($urandom_range(5) == 0) v[23:0] = 24'($urandom);  // junk after a NUL
    return v;
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] op, logic [2:0] crit);
    in_item_t it;
    it.opcode = op;
    it.criterion = crit;
    it.code_text = pool_text();
    it.name_text = pool_text();
    it.category_text = {$urandom, $urandom};
    it.query_text = pool_text();
    it.price_cents = ($urandom_range(1)) ? 24'($urandom_range(7)) : 24'($urandom);
    it.quantity = 16'($urandom);
    it.day = 5'($urandom);
    it.month = 4'($urandom);
    it.year = 14'($urandom);
    return it;
  endfunction

  function automatic in_item_t random_cmd();
    int          pick;
    logic [1:0]  op;
    logic [2:0]  crit;
    pick = $urandom_range(99);
    if (pick < ((sb.count < DEPTH) ? 40 : 3)) op = OP_LOAD;
    else if (pick < 55) op = OP_SORT;
    else if (pick < 80) op = OP_SEARCH;
    else op = OP_UPDATE;
    crit = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    if (op == OP_UPDATE && $urandom_range(3) != 0) crit = 3'($urandom_range(1));
    return make_cmd(op, crit);
  endfunction

  initial begin
    in_item_t it;
    int       waited;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    send_idle = 33;
    recv_idle = 84;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, field extremes, ignored sorts, every opcode.
    send_item(make_cmd(OP_SEARCH, CR_PREFIX));
    send_item(make_cmd(OP_UPDATE, CR_CODE));
    it = make_cmd(OP_LOAD, CR_CODE);
    it.code_text = '1; it.name_text = '1; it.category_text = '1;
    it.price_cents = '1; it.quantity = '1; it.day = '1; it.month = '1; it.year = '1;
    send_item(it);
    it = make_cmd(OP_LOAD, CR_CODE);
    it.code_text = '0; it.name_text = '0; it.category_text = '0;
    it.price_cents = '0; it.quantity = '0; it.day = '0; it.month = '0; it.year = '0;
    send_item(it);
    it = make_cmd(OP_LOAD, CR_CODE);
    it.code_text = 64'h4100_4242_4242_4242;  // NUL inside: tail is dropped
    it.name_text = 64'h4142_0000_0000_0000;
    send_item(it);
    send_item(make_cmd(OP_LOAD, CR_NAME));
    send_item(make_cmd(OP_SORT, CR_PREFIX));
    send_item(make_cmd(OP_SORT, 3'd5));
    send_item(make_cmd(OP_SORT, ORDER_NONE));
    it = make_cmd(OP_SEARCH, CR_CODE); it.query_text = 64'h4100_0000_0000_0000;
    send_item(it);
    it = make_cmd(OP_SEARCH, CR_PREFIX); it.query_text = '0;
    send_item(it);
    it = make_cmd(OP_SEARCH, CR_NAME); it.query_text = '1;
    send_item(it);
    send_item(make_cmd(OP_SEARCH, CR_PRICE_UP));
    send_item(make_cmd(OP_SEARCH, 3'd6));
    send_item(make_cmd(OP_SORT, CR_PRICE_DN));
    send_item(make_cmd(OP_SORT, CR_PRICE_UP));
    send_item(make_cmd(OP_SORT, CR_CODE));
    it = make_cmd(OP_UPDATE, CR_CODE); it.query_text = '1;
    send_item(it);
    send_item(make_cmd(OP_SORT, CR_NAME));
    it = make_cmd(OP_UPDATE, CR_NAME); it.query_text = 64'h4142_0000_0000_0000;
    send_item(it);
    send_item(make_cmd(OP_UPDATE, CR_PREFIX));
    send_item(make_cmd(OP_UPDATE, CR_PRICE_DN));

    // Random part in three idling phases.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle = 84; recv_idle = 33;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0; recv_idle = 0;
      end
      send_item(random_cmd());
    end
    send_item(make_cmd(OP_SEARCH, CR_PREFIX));
    in_valid <= 1'b0;

    // Drain, then let any trailing work settle.
    waited = 0;
    while (sb.pending_results.size() != 0 && waited < STALL_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (5000) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
